>>> sv/crc32_word_msb_first_core_defines.svh
// Assertion macros shared by the CRC core RTL.
`ifndef CRC32_WORD_MSB_FIRST_CORE_DEFINES_SVH
`define CRC32_WORD_MSB_FIRST_CORE_DEFINES_SVH

// Checked only outside reset.
`define CRC32W_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CRC32W_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/crc32w_pkg.sv
package crc32w_pkg;

	localparam int CRC_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int WORD_BYTES = CRC_W / BYTE_W;
	localparam int NB_W       = 3;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

	typedef logic [CRC_W-1:0] fold_tbl_t [CRC_W];

	// Bit-serial MSB-first division of one word; used only to build the table below.
	function automatic logic [CRC_W-1:0] shift_word(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		r = v;
		for (int n = 0; n < CRC_W; n++) begin
			if (r[CRC_W-1]) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	function automatic fold_tbl_t build_fold_tbl();
		fold_tbl_t t;
		for (int i = 0; i < CRC_W; i++) begin
			t[i] = shift_word(CRC_W'(1) << i);
		end
		return t;
	endfunction

	// Column i: contribution of input bit i after 32 shifts (the update is linear).
	localparam fold_tbl_t FOLD_TBL = build_fold_tbl();

	// One-level XOR network: each set bit selects its constant column.
	function automatic logic [CRC_W-1:0] fold_word(input logic [CRC_W-1:0] x);
		logic [CRC_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (x[i]) begin
				acc = acc ^ FOLD_TBL[i];
			end
		end
		return acc;
	endfunction

endpackage

>>> sv/crc32w_req_if.sv
interface crc32w_req_if;
	logic                              valid;
	logic                              ready;
	logic [crc32w_pkg::CRC_W-1:0]      data_word;
	logic [crc32w_pkg::NB_W-1:0]       valid_bytes;
	logic                              first;
	logic [crc32w_pkg::CRC_W-1:0]      seed;

	modport source (output valid, output data_word, output valid_bytes, output first,
		output seed, input ready);
	modport sink (input valid, input data_word, input valid_bytes, input first,
		input seed, output ready);
endinterface

>>> sv/crc32w_rsp_if.sv
interface crc32w_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [crc32w_pkg::CRC_W-1:0]      crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

>>> sv/crc32w_fold.sv
// Masks the unused upper bytes and folds the word into the base CRC.
module crc32w_fold (
	input  logic [crc32w_pkg::CRC_W-1:0] base,
	input  logic [crc32w_pkg::CRC_W-1:0] data_word,
	input  logic [crc32w_pkg::NB_W-1:0]  valid_bytes,
	output logic [crc32w_pkg::CRC_W-1:0] crc
);

	logic [crc32w_pkg::CRC_W-1:0] masked;

	always_comb begin
		for (int k = 0; k < crc32w_pkg::WORD_BYTES; k++) begin
			// counts above four saturate naturally: every byte stays enabled
			masked[k*crc32w_pkg::BYTE_W +: crc32w_pkg::BYTE_W] =
				(valid_bytes > crc32w_pkg::NB_W'(k)) ?
				data_word[k*crc32w_pkg::BYTE_W +: crc32w_pkg::BYTE_W] : '0;
		end
		if (valid_bytes == '0) begin
			crc = base;
		end else begin
			crc = crc32w_pkg::fold_word(base ^ masked);
		end
	end

endmodule

>>> sv/crc32_word_msb_first_core.sv
// An accepted item is registered in stage one, then in the result register that drives rsp.
// Throughput: one item per cycle while rsp is not stalled; the full 32-bit MSB-first CRC update
// is one XOR network. The rate is set by the loop through the running CRC register.
// Reset (arst_n low, asynchronous): both stages empty, running CRC cleared to zero.
`include "crc32_word_msb_first_core_defines.svh"

module crc32_word_msb_first_core (
	input  logic              clk,
	input  logic              arst_n,
	crc32w_req_if.sink        req,
	crc32w_rsp_if.source      rsp
);

	// Stage one: registered copy of the accepted item.
	logic                              valid_s1;
	logic [crc32w_pkg::CRC_W-1:0]      data_word_s1;
	logic [crc32w_pkg::NB_W-1:0]       valid_bytes_s1;
	logic                              first_s1;
	logic [crc32w_pkg::CRC_W-1:0]      seed_s1;

	// Result register. crc_q doubles as the running CRC: each item's result is
	// exactly the state the next item starts from, unless that item has first set.
	logic                              out_valid_q;
	logic [crc32w_pkg::CRC_W-1:0]      crc_q;

	logic                              accept;
	logic                              advance;
	logic [crc32w_pkg::CRC_W-1:0]      base;
	logic [crc32w_pkg::CRC_W-1:0]      crc_next;

	// Stage one moves into the result register when that register is
	// empty or its item is being taken this cycle.
	assign advance = valid_s1 && (!out_valid_q || rsp.ready);
	// Stage one takes a new item while its current one leaves, so a
	// stalled result does not block input until stage one is also full.
	assign req.ready = !valid_s1 || advance;
	assign accept = req.valid && req.ready;

	// The first item of a run starts from the seed instead of the stored CRC.
	assign base = first_s1 ? seed_s1 : crc_q;

	crc32w_fold u_fold (
		.base        (base),
		.data_word   (data_word_s1),
		.valid_bytes (valid_bytes_s1),
		.crc         (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			crc_q       <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				crc_q       <= crc_next;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_word_s1   <= req.data_word;
			valid_bytes_s1 <= req.valid_bytes;
			first_s1       <= req.first;
			seed_s1        <= req.seed;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.crc_value = crc_q;

	`CRC32W_ASSERT(a_advance_fills_out, advance |=> out_valid_q,
		"result register not loaded on advance")
	`CRC32W_ASSERT(a_stall_only_when_full,
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready),
		"input stalled while a stage is free")
	`CRC32W_ASSERT(a_hold_s1, (valid_s1 && !advance) |=> valid_s1,
		"stage one item dropped")
	`CRC32W_ASSERT(a_seed_passthru,
		(advance && first_s1 && valid_bytes_s1 == '0) |=> (crc_q == $past(seed_s1)),
		"seed not passed on empty first word")
	`CRC32W_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!valid_s1 && !out_valid_q),
		"stages not empty in reset")

endmodule

>>> bench/crc32_word_msb_first_core_tb.sv
`timescale 1ns / 100ps

module crc32_word_msb_first_core_tb;

	localparam int CLK_HALF    = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RAND_WORDS  = 900;
	localparam int DRAIN_WAIT  = 8;

	// One word offered to the core, as it sits in the backlog.
	typedef struct {
		logic [crc32w_pkg::CRC_W-1:0] data_word;
		logic [crc32w_pkg::NB_W-1:0]  valid_bytes;
		logic                         first;
		logic [crc32w_pkg::CRC_W-1:0] seed;
	} crc_word_t;

	logic clk;
	logic arst_n;

	crc32w_req_if req_if ();
	crc32w_rsp_if rsp_if ();

	crc32_word_msb_first_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Words waiting to be offered, and the CRC values owed by the core, oldest first.
	crc_word_t                    word_backlog [$];
	logic [crc32w_pkg::CRC_W-1:0] crc_expected [$];

	// Predictor copy of the running CRC register.
	logic [crc32w_pkg::CRC_W-1:0] crc_running;

	int unsigned queued_cnt;
	int unsigned accepted_cnt;
	int unsigned error_cnt;
	int unsigned cycle_cnt;

	// Idle odds in percent, changed only at falling edges.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// Long receiver hold-off: the sequencer bumps the request count, the monitor serves it.
	int unsigned hold_reqs;
	int unsigned hold_done;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Bit-serial division, MSB first, 32 shifts per word.
	function automatic logic [crc32w_pkg::CRC_W-1:0] divide_word(
		input logic [crc32w_pkg::CRC_W-1:0] crc,
		input logic [crc32w_pkg::CRC_W-1:0] word);
		logic [crc32w_pkg::CRC_W-1:0] r;
		r = crc ^ word;
		for (int n = 0; n < crc32w_pkg::CRC_W; n++) begin
			if (r[crc32w_pkg::CRC_W-1]) begin
				r = (r << 1) ^ crc32w_pkg::CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	// Advances the predicted running CRC by one accepted word and returns the new value.
	function automatic logic [crc32w_pkg::CRC_W-1:0] crc_fold_item(
		input logic [crc32w_pkg::CRC_W-1:0] data_word,
		input logic [crc32w_pkg::NB_W-1:0] valid_bytes, input logic first,
		input logic [crc32w_pkg::CRC_W-1:0] seed);
		logic [crc32w_pkg::CRC_W-1:0] base;
		logic [crc32w_pkg::CRC_W-1:0] mask;
		int unsigned                  nbytes;
		base   = first ? seed : crc_running;
		nbytes = valid_bytes;
		if (nbytes == 0) begin
			// no bytes: the base passes through untouched
			crc_running = base;
		end else begin
			if (nbytes > crc32w_pkg::WORD_BYTES) begin
				nbytes = crc32w_pkg::WORD_BYTES;
			end
			mask = '0;
			for (int b = 0; b < crc32w_pkg::WORD_BYTES; b++) begin
				if (b < nbytes) begin
					mask[b*crc32w_pkg::BYTE_W +: crc32w_pkg::BYTE_W] = '1;
				end
			end
			crc_running = divide_word(base, data_word & mask);
		end
		return crc_running;
	endfunction

	// Driver: a new word goes out only once the previous one was taken.
	// Prediction happens on the accept edge, from the values the core saw.
	always @(posedge clk or negedge arst_n) begin
		crc_word_t nxt;
		if (!arst_n) begin
			req_if.valid       <= 1'b0;
			req_if.data_word   <= '0;
			req_if.valid_bytes <= '0;
			req_if.first       <= 1'b0;
			req_if.seed        <= '0;
			crc_running        = '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				crc_expected.push_back(crc_fold_item(req_if.data_word, req_if.valid_bytes,
					req_if.first, req_if.seed));
				accepted_cnt++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = word_backlog.pop_front();
					req_if.valid       <= 1'b1;
					req_if.data_word   <= nxt.data_word;
					req_if.valid_bytes <= nxt.valid_bytes;
					req_if.first       <= nxt.first;
					req_if.seed        <= nxt.seed;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each taken result against the oldest prediction and drives ready.
	always @(posedge clk or negedge arst_n) begin
		logic [crc32w_pkg::CRC_W-1:0] want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left    <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (crc_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual crc_value %h",
						$time, rsp_if.crc_value);
					error_cnt++;
				end else begin
					want = crc_expected.pop_front();
					if (rsp_if.crc_value !== want) begin
						$display("%0t: crc_value mismatch, expected %h, actual %h",
							$time, want, rsp_if.crc_value);
						error_cnt++;
					end
				end
			end
			// a pending hold request wins over random stalls
			if (hold_done != hold_reqs) begin
				hold_done    <= hold_done + 1;
				hold_left    <= HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_word(input logic [crc32w_pkg::CRC_W-1:0] data_word,
		input logic [crc32w_pkg::NB_W-1:0] valid_bytes, input logic first,
		input logic [crc32w_pkg::CRC_W-1:0] seed);
		crc_word_t w;
		w.data_word   = data_word;
		w.valid_bytes = valid_bytes;
		w.first       = first;
		w.seed        = seed;
		word_backlog.push_back(w);
		queued_cnt++;
	endtask

	// A message: a seeded first word, whole words, and a tail of 1..4 bytes.
	// Now and then it carries on from the stored CRC instead of a seed.
	task automatic push_message(inout int unsigned budget);
		int unsigned len;
		logic        seeded;
		len    = $urandom_range(6, 1);
		seeded = ($urandom_range(9) != 0);
		for (int i = 0; i < len; i++) begin
			push_word($urandom(),
				(i == len - 1) ?
				crc32w_pkg::NB_W'($urandom_range(crc32w_pkg::WORD_BYTES, 1)) :
				crc32w_pkg::NB_W'(crc32w_pkg::WORD_BYTES),
				(i == 0) ? seeded : 1'b0, $urandom());
		end
		budget -= (len < budget) ? len : budget;
	endtask

	// Noise: any byte count the field allows, first at random.
	task automatic push_noise(inout int unsigned budget);
		push_word($urandom(), crc32w_pkg::NB_W'($urandom_range(7)),
			1'($urandom_range(1)), $urandom());
		budget -= (budget != 0) ? 1 : 0;
	endtask

	task automatic fill_random(input int unsigned count);
		int unsigned left;
		left = count;
		while (left != 0) begin
			if ($urandom_range(99) < 80) begin
				push_message(left);
			end else begin
				push_noise(left);
			end
		end
	endtask

	// Sender pause: nothing new until every owed result is back.
	task automatic wait_drained();
		wait (accepted_cnt == queued_cnt && crc_expected.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// Sequencer. Everything it changes is changed at a falling edge, clear of the
	// clocked blocks.
	initial begin
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.data_word   = '0;
		req_if.valid_bytes = '0;
		req_if.first       = 1'b0;
		req_if.seed        = '0;
		rsp_if.ready       = 1'b0;
		queued_cnt         = 0;
		accepted_cnt       = 0;
		error_cnt          = 0;
		cycle_cnt          = 0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		hold_reqs          = 0;
		hold_done          = 0;
		crc_running        = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words, no idling.
		// Right after reset: continue from the cleared register.
		push_word(32'h0000_0000, 3'd4, 1'b0, 32'hFFFF_FFFF);
		push_word(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h0000_0000);
		// seeded starts at both seed extremes
		push_word(32'h0000_0000, 3'd4, 1'b1, 32'hFFFF_FFFF);
		push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 32'h0000_0000);
		push_word(32'h8000_0000, 3'd4, 1'b1, 32'h0000_0000);
		push_word(32'h0000_0001, 3'd4, 1'b1, 32'h0000_0000);
		// every byte count on an all-ones word, including the empty and oversize ones
		for (int nb = 0; nb < 8; nb++) begin
			push_word(32'hFFFF_FFFF, crc32w_pkg::NB_W'(nb), 1'b0, 32'h1234_5678);
		end
		// empty word with first: the seed comes straight out
		push_word(32'hDEAD_BEEF, 3'd0, 1'b1, 32'hA5A5_5A5A);
		push_word(32'hDEAD_BEEF, 3'd0, 1'b0, 32'h0000_0000);
		// partial tails after a seeded start
		push_word(32'h0102_0304, 3'd4, 1'b1, 32'hFFFF_FFFF);
		push_word(32'hAABB_CCDD, 3'd3, 1'b0, 32'h0000_0000);
		push_word(32'h1122_3344, 3'd2, 1'b1, 32'h8000_0001);
		push_word(32'h5566_7788, 3'd1, 1'b0, 32'hFFFF_FFFF);
		// oversize count with first
		push_word(32'h7FFF_FFFE, 3'd7, 1'b1, 32'h7FFF_FFFF);
		push_word(32'h0000_0000, 3'd5, 1'b0, 32'h0000_0000);
		wait_drained();

		// Phase 1: no idling, plus a long receiver hold while the backlog keeps
		// offering, so the core fills and stalls its input.
		fill_random(RAND_WORDS / 4);
		hold_reqs = hold_reqs + 1;
		wait_drained();

		// Phase 2: sender idles.
		send_idle_pct = 46;
		fill_random(RAND_WORDS / 4);
		wait_drained();

		// Phase 3: receiver stalls.
		send_idle_pct = 0;
		recv_idle_pct = 46;
		fill_random(RAND_WORDS / 4);
		wait_drained();

		// Phase 4: both sides idle.
		send_idle_pct = 26;
		recv_idle_pct = 26;
		fill_random(RAND_WORDS / 4);
		wait_drained();

		if (error_cnt == 0 && crc_expected.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
